// File: src/dqms_pkg.sv
`default_nettype none
package dqms_pkg;

   localparam int DEPTH     = 64;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int VALUE_W   = 32;
   localparam int CMD_W     = 3;
   localparam int OUT_CNT_W = 7;
   localparam int RSP_W     = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_SEARCH     = 3'd4,
      CMD_INSERT     = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_PRESENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FINISH
   } seq_state_type;

   // Ring slot that lies off places after idx; off is always below DEPTH.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, idx} + {1'b0, off};
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         sum = sum - (IDX_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // The result field holds the whole count, as OUT_CNT_W is as wide as CNT_W.
   function automatic logic [OUT_CNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
      logic [CNT_W+OUT_CNT_W-1:0] wide;
      wide = {{OUT_CNT_W{1'b0}}, c};
      return wide[OUT_CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: src/deque_with_member_search.sv
`default_nettype none
// Bounded double-ended queue of signed 32-bit values with member search.
// Request channel: req_tuser carries the command (push front, push back,
// pop front, pop back, search, insert at back if absent) and req_tdata the
// value. Every request item yields exactly one response item on rsp_, which
// reports status, found flag, entry count and empty flag.
// Entries live in a single-port-write, registered-read RAM used as a ring.
// Pushes and pops go from acceptance straight to the finish step, which
// registers the response once the output register is free. Search and insert
// first walk the live entries through the RAM read port, one entry per cycle,
// with the compare in the cycle after the read, then reach the finish step.
// req_tready is low while an item is in progress, so the next request item
// is taken only after the previous one has committed its response.
// The response sits in an output register, so a new request item is taken
// while an earlier response still waits; if the receiver holds rsp_tready
// low, the finished item waits in its final step until the register frees.
// Synchronous reset empties the queue (head and count to zero) and drops
// any pending response. The RAM contents are not cleared; only entries that
// were written are ever read.
module deque_with_member_search (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] value (signed)
   input  wire logic [2:0]  req_tuser,  // [2:0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [2] found, [9:3] entry_count, [10] is_empty, [15:11] zero
   output logic [dqms_pkg::RSP_W-1:0] rsp_tdata
);
   import dqms_pkg::*;

   seq_state_type       state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   cmd_type             cmd_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [CNT_W-1:0]    scan_issue_ff, scan_issue_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                out_free;
   logic                commit;
   logic                issue_more;
   logic                full;
   logic                is_scan_cmd;
   status_type          status;
   logic                found_out;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [VALUE_W-1:0]  ram_rd_data;

   dqms_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready  = (state_ff == SEQ_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign commit      = (state_ff == SEQ_FINISH) && out_free;
   assign issue_more  = (scan_issue_ff < count_ff);
   assign full        = (count_ff >= CNT_W'(DEPTH));
   assign is_scan_cmd = (req_tuser == CMD_SEARCH) || (req_tuser == CMD_INSERT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = is_scan_cmd ? SEQ_SCAN : SEQ_FINISH;
            end
         end
         SEQ_SCAN: begin
            // Done once every entry was read and the last compare is in.
            if (!issue_more && !cmp_valid_ff) begin
               state_in = SEQ_FINISH;
            end
         end
         SEQ_FINISH: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      scan_issue_in = scan_issue_ff;
      cmp_valid_in  = 1'b0;
      found_in      = found_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ring_add(head_ff, scan_issue_ff[IDX_W-1:0]);
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ring_add(head_ff, count_ff[IDX_W-1:0]);
      status        = ST_DONE;
      found_out     = 1'b0;

      case (state_ff)
         SEQ_IDLE: begin
            scan_issue_in = '0;
            found_in      = 1'b0;
         end
         SEQ_SCAN: begin
            if (issue_more) begin
               ram_rd_en     = 1'b1;
               scan_issue_in = scan_issue_ff + CNT_W'(1);
               cmp_valid_in  = 1'b1;
            end
            if (cmp_valid_ff && (ram_rd_data == value_ff)) begin
               found_in = 1'b1;
            end
         end
         SEQ_FINISH: begin
            case (cmd_ff)
               CMD_PUSH_FRONT: begin
                  if (full) begin
                     status = ST_FULL;
                  end else begin
                     head_in     = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
                     ram_wr_addr = head_in;
                     ram_wr_en   = commit;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               CMD_PUSH_BACK: begin
                  if (full) begin
                     status = ST_FULL;
                  end else begin
                     ram_wr_en = commit;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               CMD_POP_FRONT: begin
                  if (count_ff == '0) begin
                     status = ST_EMPTY;
                  end else begin
                     head_in  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               CMD_POP_BACK: begin
                  if (count_ff == '0) begin
                     status = ST_EMPTY;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               CMD_SEARCH: begin
                  found_out = found_ff;
               end
               CMD_INSERT: begin
                  if (found_ff) begin
                     found_out = 1'b1;
                     status    = ST_PRESENT;
                  end else if (full) begin
                     status = ST_FULL;
                  end else begin
                     ram_wr_en = commit;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               default: begin
                  status = ST_DONE;
               end
            endcase
            if (!commit) begin
               head_in  = head_ff;
               count_in = count_ff;
            end
         end
         default: begin
            scan_issue_in = '0;
         end
      endcase

      rsp_data_in = {{(RSP_W - OUT_CNT_W - 4){1'b0}}, (count_in == '0),
                     count_field(count_in), found_out, status};

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_tuser);
         value_ff <= req_tdata;
      end
      scan_issue_ff <= scan_issue_in;
      found_ff      <= found_in;
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: src/dqms_ram.sv
`default_nettype none
module dqms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: src/dqms_checker.sv
`default_nettype none
module dqms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic [2:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [dqms_pkg::RSP_W-1:0] rsp_tdata
);
   import dqms_pkg::*;

   // A stalled response item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response item changed while stalled");

   // Reset drops any pending response.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // One item at a time: no request is taken in the cycle after one was.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in progress");

   // A skipped insert reports the value as found, and an empty pop
   // leaves the queue empty.
   a_status_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[1:0] != ST_PRESENT) || rsp_tdata[2]) &&
                     ((rsp_tdata[1:0] != ST_EMPTY) || rsp_tdata[10]))
      else $error("status and flags disagree");

endmodule

bind deque_with_member_search dqms_checker u_checker (.*);
`default_nettype wire

// File: bench/tb_deque_with_member_search.sv
`timescale 1ns / 1ps

module tb_deque_with_member_search;
   import dqms_pkg::*;

   // Commands 6 and 7 are not defined; the block must treat them as no-ops.
   localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

   // What one response item should carry, from the highest field down.
   typedef struct packed {
      logic                 is_empty;
      logic [OUT_CNT_W-1:0] entry_count;
      logic                 found;
      status_type           status;
   } deque_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata;   // [31:0] value (signed)
   logic [CMD_W-1:0]      req_tuser;   // [2:0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [1:0] status, [2] found, [9:3] entry_count, [10] is_empty, [15:11] zero
   logic [RSP_W-1:0]      rsp_tdata;

   // Shadow copy of the ring, kept in step with every accepted item.
   logic [VALUE_W-1:0]    shadow_ring [DEPTH];
   logic [IDX_W-1:0]      shadow_head;
   logic [CNT_W-1:0]      shadow_count;

   deque_outcome_type     pending_outcomes [$];
   int                    failure_count;
   int unsigned           send_idle_pct;
   int unsigned           recv_idle_pct;

   deque_with_member_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Ring slot that lies offset places after the shadow head.
   function automatic int unsigned shadow_slot(input int unsigned offset);
      return (int'(shadow_head) + offset) % DEPTH;
   endfunction

   // Applies one command to the shadow deque and returns the response it
   // should produce. The membership scan only looks at live entries.
   function automatic deque_outcome_type apply_to_shadow(input logic [CMD_W-1:0] cmd,
                                                         input logic [VALUE_W-1:0] value);
      deque_outcome_type outcome;
      logic              hit;
      logic              full;
      int                i;
      hit = 1'b0;
      for (i = 0; i < int'(shadow_count); i++) begin
         if (shadow_ring[shadow_slot(i)] == value) begin
            hit = 1'b1;
         end
      end
      full           = (shadow_count >= CNT_W'(DEPTH));
      outcome.status = ST_DONE;
      outcome.found  = 1'b0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (full) begin
               outcome.status = ST_FULL;
            end else begin
               shadow_head              = IDX_W'(shadow_slot(DEPTH - 1));
               shadow_ring[shadow_head] = value;
               shadow_count             = shadow_count + 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               outcome.status = ST_FULL;
            end else begin
               shadow_ring[shadow_slot(shadow_count)] = value;
               shadow_count = shadow_count + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_count == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               shadow_head  = IDX_W'(shadow_slot(1));
               shadow_count = shadow_count - 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (shadow_count == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               shadow_count = shadow_count - 1'b1;
            end
         end
         CMD_SEARCH: begin
            outcome.found = hit;
         end
         CMD_INSERT: begin
            if (hit) begin
               outcome.found  = 1'b1;
               outcome.status = ST_PRESENT;
            end else if (full) begin
               outcome.status = ST_FULL;
            end else begin
               shadow_ring[shadow_slot(shadow_count)] = value;
               shadow_count = shadow_count + 1'b1;
            end
         end
         default: begin
         end
      endcase
      outcome.entry_count = OUT_CNT_W'(shadow_count);
      outcome.is_empty    = (shadow_count == 0);
      return outcome;
   endfunction

   // Picks a value that is often already stored, so searches and inserts
   // hit as well as miss.
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35 && shadow_count != 0) begin
         return shadow_ring[shadow_slot($urandom_range(int'(shadow_count) - 1))];
      end
      if (r < 55) begin
         case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h5555_5555;
            6: return 32'hAAAA_AAAA;
            default: return 32'h8000_0001;
         endcase
      end
      return $urandom;
   endfunction

   // Sends one item, with random idle cycles ahead of it, and records the
   // outcome once the block has taken it.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= CMD_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_outcomes.push_back(apply_to_shadow(cmd, value));
   endtask

   // Holds the request side quiet until every outstanding response is back.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Pops and searches on an empty deque, plus the two undefined commands.
   task automatic test_empty_cases();
      send_item(CMD_POP_FRONT, 32'h1234_5678);
      send_item(CMD_POP_BACK, 32'hFFFF_FFFF);
      send_item(CMD_SEARCH, 32'h0000_0000);
      send_item(CMD_UNDEF_LO, 32'h0000_0007);
      send_item(CMD_UNDEF_HI, 32'h8000_0000);
      send_item(CMD_POP_FRONT, 32'h0000_0000);
   endtask

   // Extreme values at both ends, hits and misses, insert of present and
   // absent values.
   task automatic test_value_extremes();
      send_item(CMD_PUSH_BACK, 32'h7FFF_FFFF);
      send_item(CMD_PUSH_FRONT, 32'h8000_0000);
      send_item(CMD_PUSH_BACK, 32'h0000_0000);
      send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      send_item(CMD_PUSH_BACK, 32'h0000_0001);
      send_item(CMD_SEARCH, 32'h8000_0000);
      send_item(CMD_SEARCH, 32'h7FFF_FFFF);
      send_item(CMD_SEARCH, 32'h7FFF_FFFE);
      send_item(CMD_INSERT, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'h5555_5555);
      send_item(CMD_INSERT, 32'hAAAA_AAAA);
      send_item(CMD_SEARCH, 32'hAAAA_AAAA);
      send_item(CMD_POP_FRONT, 32'h0000_0000);
      send_item(CMD_POP_BACK, 32'h0000_0000);
      send_item(CMD_SEARCH, 32'hFFFF_FFFF);
      send_item(CMD_UNDEF_HI, 32'hAAAA_AAAA);
   endtask

   // Fills the deque to the brim, checks every refusal when full, then
   // drains it past empty. Mixed front and back traffic makes the head wrap.
   task automatic test_full_and_drain();
      logic [VALUE_W-1:0] value;
      while (shadow_count < CNT_W'(DEPTH)) begin
         case ($urandom_range(2))
            0: send_item(CMD_PUSH_FRONT, pick_value());
            1: send_item(CMD_PUSH_BACK, pick_value());
            default: send_item(CMD_INSERT, $urandom);
         endcase
      end
      send_item(CMD_PUSH_FRONT, $urandom);
      send_item(CMD_PUSH_BACK, $urandom);
      send_item(CMD_INSERT, $urandom);
      value = shadow_ring[shadow_slot(DEPTH - 1)];
      send_item(CMD_INSERT, value);
      send_item(CMD_SEARCH, value);
      send_item(CMD_SEARCH, shadow_ring[shadow_head]);
      while (shadow_count != 0) begin
         if ($urandom_range(1) == 0) begin
            send_item(CMD_POP_FRONT, $urandom);
         end else begin
            send_item(CMD_POP_BACK, $urandom);
         end
      end
      send_item(CMD_POP_BACK, $urandom);
      send_item(CMD_POP_FRONT, $urandom);
   endtask

   // Random traffic that drifts between filling and draining, so the count
   // sweeps the whole range and sits at full and empty for a while.
   task automatic test_random_mix(input int item_total);
      logic             growing;
      logic [CMD_W-1:0] cmd;
      int unsigned      r;
      growing = 1'b1;
      repeat (item_total) begin
         if (shadow_count >= CNT_W'(DEPTH) && $urandom_range(3) == 0) begin
            growing = 1'b0;
         end else if (shadow_count == 0 && $urandom_range(3) == 0) begin
            growing = 1'b1;
         end else if ($urandom_range(99) == 0) begin
            growing = ~growing;
         end
         r = $urandom_range(99);
         if (growing) begin
            cmd = (r < 30) ? CMD_PUSH_BACK :
                  (r < 50) ? CMD_PUSH_FRONT :
                  (r < 65) ? CMD_INSERT :
                  (r < 75) ? CMD_POP_FRONT :
                  (r < 85) ? CMD_POP_BACK :
                  (r < 97) ? CMD_SEARCH : CMD_UNDEF_LO;
         end else begin
            cmd = (r < 10) ? CMD_PUSH_BACK :
                  (r < 20) ? CMD_PUSH_FRONT :
                  (r < 30) ? CMD_INSERT :
                  (r < 55) ? CMD_POP_FRONT :
                  (r < 80) ? CMD_POP_BACK :
                  (r < 95) ? CMD_SEARCH : CMD_UNDEF_LO;
         end
         if (cmd == CMD_UNDEF_LO && $urandom_range(1) == 1) begin
            cmd = CMD_UNDEF_HI;
         end
         send_item(cmd, pick_value());
      end
   endtask

   // Receiver: random backpressure at the current idle rate.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every accepted response is matched against the oldest outcome waiting.
   always @(posedge clock) begin
      deque_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response item with no outcome pending: rsp_tdata %h", rsp_tdata);
            failure_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
               failure_count++;
            end
            if (rsp_tdata[2] !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_tdata[2]);
               failure_count++;
            end
            if (rsp_tdata[9:3] !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", want.entry_count,
                      rsp_tdata[9:3]);
               failure_count++;
            end
            if (rsp_tdata[10] !== want.is_empty) begin
               $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_tdata[10]);
               failure_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_deque_with_member_search failed");
      $finish;
   end

   initial begin
      failure_count = 0;
      shadow_head   = '0;
      shadow_count  = '0;
      send_idle_pct = 33;
      recv_idle_pct = 74;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_cases();
      test_value_extremes();
      test_random_mix(300);
      wait_for_responses();

      send_idle_pct = 74;
      recv_idle_pct = 33;
      test_full_and_drain();
      test_random_mix(300);
      wait_for_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_mix(300);
      test_full_and_drain();

      wait_for_responses();
      repeat (DEPTH + 8) @(posedge clock);
      if (failure_count == 0) begin
         $display("tb_deque_with_member_search passed");
      end else begin
         $display("tb_deque_with_member_search failed");
      end
      $finish;
   end

endmodule
